// File: hdl/rfc_pkg.sv
// Shared constants, types and control structs of the rectangle fill canvas.
`default_nettype none
package rfc_pkg;

  localparam int CANVAS_SIDE   = 128;
  localparam int COORD_W       = $clog2(CANVAS_SIDE);
  localparam int EDGE_W        = COORD_W + 1;
  localparam int ADDR_W        = 2 * COORD_W;
  localparam int CANVAS_PIXELS = CANVAS_SIDE * CANVAS_SIDE;
  localparam int CH_W          = 8;
  localparam int PIX_W         = 3 * CH_W;
  localparam int SIZE_W        = 8;
  localparam int MODE_W        = 2;

  localparam logic [EDGE_W-1:0] SIDE_EDGE   = EDGE_W'(CANVAS_SIDE);
  localparam logic [CH_W-1:0]   CH_FULL     = {CH_W{1'b1}};
  localparam logic [PIX_W-1:0]  WHITE_PIXEL = {PIX_W{1'b1}};

  typedef enum logic [MODE_W-1:0] {
    MODE_FILL  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [COORD_W-1:0] rect_x;
    logic [COORD_W-1:0] rect_y;
    logic [SIZE_W-1:0]  rect_width;
    logic [SIZE_W-1:0]  rect_height;
    logic [CH_W-1:0]    red;
    logic [CH_W-1:0]    green;
    logic [CH_W-1:0]    blue;
  } item_t;

  typedef struct packed {
    logic [CH_W-1:0]   pixel_red;
    logic [CH_W-1:0]   pixel_green;
    logic [CH_W-1:0]   pixel_blue;
    logic [EDGE_W-1:0] extent_x;
    logic [EDGE_W-1:0] extent_y;
  } result_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic fill_step;
    logic clr_step;
    logic rd_en;
    logic out_load;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic fill_empty;
    logic fill_last;
    logic clr_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// File: hdl/rfc_in_if.sv
// Input channel: one drawing or read command per beat.
`default_nettype none
interface rfc_in_if
  import rfc_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic [MODE_W-1:0]  mode;
  logic [COORD_W-1:0] rect_x;
  logic [COORD_W-1:0] rect_y;
  logic [SIZE_W-1:0]  rect_width;
  logic [SIZE_W-1:0]  rect_height;
  logic [CH_W-1:0]    red;
  logic [CH_W-1:0]    green;
  logic [CH_W-1:0]    blue;

  modport source (
    output valid, mode, rect_x, rect_y, rect_width, rect_height, red, green, blue,
    input  ready
  );
  modport sink (
    input  valid, mode, rect_x, rect_y, rect_width, rect_height, red, green, blue,
    output ready
  );
endinterface
`default_nettype wire

// File: hdl/rfc_out_if.sv
// Result channel: pixel value and current extents, one beat per command.
`default_nettype none
interface rfc_out_if
  import rfc_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [CH_W-1:0]   pixel_red;
  logic [CH_W-1:0]   pixel_green;
  logic [CH_W-1:0]   pixel_blue;
  logic [EDGE_W-1:0] extent_x;
  logic [EDGE_W-1:0] extent_y;

  modport source (
    output valid, pixel_red, pixel_green, pixel_blue, extent_x, extent_y,
    input  ready
  );
  modport sink (
    input  valid, pixel_red, pixel_green, pixel_blue, extent_x, extent_y,
    output ready
  );
endinterface
`default_nettype wire

// File: hdl/rectangle_fill_canvas_top.sv
// Top level of the rectangle fill canvas: 128x128 RGB canvas with fill, read and clear.
// Every command gives exactly one result beat. The canvas is a single-port-write
// memory written one pixel per cycle, so a fill writes each clipped pixel of its
// rectangle in turn and a clear sweeps every pixel of the canvas. After reset the
// block sweeps the canvas to white and holds in_ch.ready low meanwhile. A new
// command is taken as soon as the previous one has finished, even while its
// result still waits in the output register.
`default_nettype none
module rectangle_fill_canvas_top
  import rfc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  rfc_in_if.sink    in_ch,
  rfc_out_if.source out_ch
);

  item_t   in_item;
  result_t out_res;
  cmd_t    cmd;
  status_t sts;
  logic    out_valid;

  assign in_item = '{
    mode:        in_ch.mode,
    rect_x:      in_ch.rect_x,
    rect_y:      in_ch.rect_y,
    rect_width:  in_ch.rect_width,
    rect_height: in_ch.rect_height,
    red:         in_ch.red,
    green:       in_ch.green,
    blue:        in_ch.blue
  };

  rfc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rfc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.valid       = out_valid;
  assign out_ch.pixel_red   = out_res.pixel_red;
  assign out_ch.pixel_green = out_res.pixel_green;
  assign out_ch.pixel_blue  = out_res.pixel_blue;
  assign out_ch.extent_x    = out_res.extent_x;
  assign out_ch.extent_y    = out_res.extent_y;

endmodule
`default_nettype wire

// File: hdl/rfc_ctrl.sv
// Controller state machine: sequences init sweep, fill, clear, read and result.
`default_nettype none
module rfc_ctrl
  import rfc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [MODE_W-1:0] in_mode,
  output logic                   in_ready,
  input  wire status_t           sts,
  output cmd_t                   cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_FILL,
    S_CLEAR,
    S_READ,
    S_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (in_mode)
            MODE_FILL:  state_nxt = S_FILL;
            MODE_READ:  state_nxt = S_READ;
            MODE_CLEAR: state_nxt = S_CLEAR;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_FILL: begin
        if (sts.fill_empty) begin
          state_nxt = S_DONE;
        end else begin
          cmd.fill_step = 1'b1;
          if (sts.fill_last) state_nxt = S_DONE;
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = S_DONE;
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/rfc_dp.sv
// Datapath: command registers, scan counters, canvas memory, extents, result register.
`default_nettype none
module rfc_dp
  import rfc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire item_t   in_item,
  input  wire cmd_t    cmd,
  output status_t      sts,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_res
);

  localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};

  // Latched command
  logic [MODE_W-1:0]  mode_r;
  logic [COORD_W-1:0] x_r, y_r;
  logic [EDGE_W-1:0]  right_r, bottom_r;
  logic [PIX_W-1:0]   colour_r;

  // Scan counters
  logic [COORD_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;

  // Extents
  logic [EDGE_W-1:0]  max_right_r, max_right_nxt, max_bottom_r, max_bottom_nxt;

  // Result
  logic               out_valid_r;
  result_t            out_res_r;

  // Canvas
  logic [PIX_W-1:0]   canvas_mem [CANVAS_PIXELS];
  logic [PIX_W-1:0]   rdata_r;
  logic               mem_we;
  logic [PIX_W-1:0]   mem_wdata;

  logic [EDGE_W:0]    right_sum, bottom_sum;
  logic [EDGE_W-1:0]  right_clip, bottom_clip;
  logic               is_white;
  logic [EDGE_W-1:0]  cx_inc, cy_inc;

  // Clip edges at the canvas side
  assign right_sum   = (EDGE_W+1)'(in_item.rect_x) + (EDGE_W+1)'(in_item.rect_width);
  assign bottom_sum  = (EDGE_W+1)'(in_item.rect_y) + (EDGE_W+1)'(in_item.rect_height);
  assign right_clip  = (right_sum > (EDGE_W+1)'(CANVAS_SIDE)) ? SIDE_EDGE
                                                              : right_sum[EDGE_W-1:0];
  assign bottom_clip = (bottom_sum > (EDGE_W+1)'(CANVAS_SIDE)) ? SIDE_EDGE
                                                               : bottom_sum[EDGE_W-1:0];
  assign is_white    = (in_item.red == CH_FULL) && (in_item.green == CH_FULL) &&
                       (in_item.blue == CH_FULL);

  assign cx_inc = EDGE_W'(cx_r) + EDGE_W'(1);
  assign cy_inc = EDGE_W'(cy_r) + EDGE_W'(1);

  always_comb begin
    sts.fill_empty = (EDGE_W'(x_r) >= right_r) || (EDGE_W'(y_r) >= bottom_r);
    sts.fill_last  = (cx_inc == right_r) && (cy_inc == bottom_r);
    sts.clr_last   = (cx_r == COORD_MAX) && (cy_r == COORD_MAX);
    sts.out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    max_right_nxt  = max_right_r;
    max_bottom_nxt = max_bottom_r;
    if (cmd.load) begin
      if (in_item.mode == MODE_FILL) begin
        cx_nxt = in_item.rect_x;
        cy_nxt = in_item.rect_y;
        if (!is_white) begin
          if (right_clip > max_right_r)   max_right_nxt  = right_clip;
          if (bottom_clip > max_bottom_r) max_bottom_nxt = bottom_clip;
        end
      end else if (in_item.mode == MODE_CLEAR) begin
        cx_nxt         = '0;
        cy_nxt         = '0;
        max_right_nxt  = '0;
        max_bottom_nxt = '0;
      end
    end else if (cmd.fill_step) begin
      // wrap to the left edge at the clipped right edge
      if (cx_inc == right_r) begin
        cx_nxt = x_r;
        cy_nxt = cy_inc[COORD_W-1:0];
      end else begin
        cx_nxt = cx_inc[COORD_W-1:0];
      end
    end else if (cmd.clr_step) begin
      cx_nxt = cx_inc[COORD_W-1:0];
      if (cx_r == COORD_MAX) cy_nxt = cy_inc[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r         <= '0;
      cy_r         <= '0;
      max_right_r  <= '0;
      max_bottom_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      cx_r         <= cx_nxt;
      cy_r         <= cy_nxt;
      max_right_r  <= max_right_nxt;
      max_bottom_r <= max_bottom_nxt;
      if (cmd.out_load)    out_valid_r <= 1'b1;
      else if (out_ready)  out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_item.mode;
      x_r      <= in_item.rect_x;
      y_r      <= in_item.rect_y;
      right_r  <= right_clip;
      bottom_r <= bottom_clip;
      colour_r <= {in_item.red, in_item.green, in_item.blue};
    end
    if (cmd.out_load) begin
      out_res_r.pixel_red   <= (mode_r == MODE_READ) ? rdata_r[PIX_W-1 -: CH_W]  : '0;
      out_res_r.pixel_green <= (mode_r == MODE_READ) ? rdata_r[2*CH_W-1 -: CH_W] : '0;
      out_res_r.pixel_blue  <= (mode_r == MODE_READ) ? rdata_r[CH_W-1:0]         : '0;
      out_res_r.extent_x    <= max_right_r;
      out_res_r.extent_y    <= max_bottom_r;
    end
  end

  assign mem_we    = cmd.fill_step || cmd.clr_step;
  assign mem_wdata = cmd.fill_step ? colour_r : WHITE_PIXEL;

  always_ff @(posedge clk) begin
    if (mem_we) canvas_mem[{cy_r, cx_r}] <= mem_wdata;
    if (cmd.rd_en) rdata_r <= canvas_mem[{y_r, x_r}];
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTHESIS
  a_extent_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (max_right_r <= SIDE_EDGE) && (max_bottom_r <= SIDE_EDGE))
    else $error("extent beyond canvas side");

  a_fill_inside: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fill_step |-> (cx_inc <= right_r) && (cy_inc <= bottom_r))
    else $error("fill write outside rectangle");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.load, cmd.fill_step, cmd.clr_step, cmd.rd_en, cmd.out_load}) <= 1)
    else $error("overlapping datapath commands");

  a_clear_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.clr_step && sts.clr_last) |=> (cx_r == '0) && (cy_r == '0))
    else $error("clear sweep did not wrap to origin");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result register overwritten while full");
`endif

endmodule
`default_nettype wire
